>>> rtl/core/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared token codes, character constants and keyword tables for the
// description-language token scanner.
// ----------------------------------------------------------------------------
package dts_pkg;

    // Table sizes
    localparam int KwCount    = 5;
    localparam int KwMax      = 8;
    localparam int PunctCount = 9;

    // Output field widths
    localparam int START_W = 24;
    localparam int LEN_W   = 16;
    localparam int LINE_W  = 16;

    // Token kinds
    localparam logic [4:0] KIND_IDENT      = 5'd0;
    localparam logic [4:0] KIND_NUMBER     = 5'd6;
    localparam logic [4:0] KIND_STRING     = 5'd7;
    localparam logic [4:0] KIND_PUNCT_BASE = 5'd8;
    localparam logic [4:0] KIND_ARROW      = 5'd17;
    localparam logic [4:0] KIND_EOF        = 5'd18;
    localparam logic [4:0] KIND_ERROR      = 5'd19;

    // Error kinds
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNTERM  = 2'd1;
    localparam logic [1:0] ERR_ARROW   = 2'd2;
    localparam logic [1:0] ERR_UNEXPEC = 2'd3;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Keyword spellings, zero padded, and their lengths
    localparam logic [7:0] KW_TEXT [KwCount][KwMax] = '{
        '{"d", "e", "f", "i", "n", "e", 8'h00, 8'h00},
        '{"e", "n", "u", "m", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "e", "n", "e", "r", "a", "t", "e"},
        '{"i", "n", "c", "l", "u", "d", "e", 8'h00},
        '{"s", "t", "r", "i", "n", "g", "s", 8'h00}
    };
    localparam logic [3:0] KW_LEN [KwCount] = '{4'd6, 4'd4, 4'd8, 4'd7, 4'd7};

    // Single-character punctuators, in kind order
    localparam logic [7:0] PUNCT [PunctCount] = '{
        ":", ",", "*", "(", ")", "{", "}", "[", "]"
    };

    // One result word
    typedef struct packed {
        logic [4:0]        kind;
        logic [1:0]        err;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]  len;
        logic [LINE_W-1:0] line;
        logic              last;
    } token_t;

endpackage

>>> rtl/core/dsl_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// dsl_token_scanner_unit
// Streaming lexical scanner: one source byte in per word, tokens out.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle while source_stall is low; the token words
// that an accepted byte closes pass through the burst buffer, then the output
// register. Most bytes close at most one token and stream at one byte per
// cycle. A byte that closes two or three tokens at once (a number ending in a
// bare '.', or a token followed directly by a punctuator, error or end of
// source) loads a three-entry burst buffer, and source_stall stays high while
// the output register drains it one word per cycle, unless token_stall holds
// it. Byte 0 ends the source, emits the end-of-source token, and the scanner
// restarts at offset 0, line 1.
// ----------------------------------------------------------------------------
module dsl_token_scanner_unit #(
    parameter int OFFSET_BITS   = 24,
    parameter int LINE_BITS     = 16,
    parameter int KEYWORD_CHARS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        source_valid,
    output logic        source_stall,
    input  logic [7:0]  source_byte,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [4:0]  token_kind,
    output logic [1:0]  error_kind,
    output logic [23:0] start_offset,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic        last_of_run
);

    localparam int OB  = OFFSET_BITS;
    localparam int LB  = LINE_BITS;
    localparam int KC  = KEYWORD_CHARS;
    localparam int WLW = $clog2(KC + 1);
    localparam int SW  = (OB > dts_pkg::START_W) ? OB : dts_pkg::START_W;
    localparam int DW  = (OB > dts_pkg::LEN_W) ? OB : dts_pkg::LEN_W;
    localparam int LW  = (LB > dts_pkg::LINE_W) ? LB : dts_pkg::LINE_W;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_STRING,
        MODE_DASH
    } mode_t;

    // Scanner state
    mode_t               mode_reg, mode_next;
    logic [OB-1:0]       off_reg, off_next;
    logic [OB-1:0]       tstart_reg, tstart_next;
    logic [LB-1:0]       line_reg, line_next;
    logic [WLW-1:0]      wlen_reg, wlen_next;
    logic [7:0]          word_reg [KC];

    // Burst buffer and output register
    dts_pkg::token_t     slot_reg [3];
    logic [1:0]          slot_cnt_reg;
    dts_pkg::token_t     out_reg;
    logic                out_valid_reg;

    // Combinational results
    dts_pkg::token_t     new_slot [3];
    logic [1:0]          new_cnt;
    logic                accept, load, can_take;

    logic [7:0]          c;
    logic                c_alpha, c_digit;
    logic [OB-1:0]       d0, dm1, dp1, dot_off;
    logic [4:0]          word_kind;
    logic [dts_pkg::LINE_W-1:0] line_out;

    logic                take_idle, eof;
    logic                idle_valid, prim_valid, dot_valid;
    dts_pkg::token_t     idle_tok, prim_tok, dot_tok;
    mode_t               idle_mode;
    logic                word_start, word_append;

    // Offset to output start field
    function automatic logic [dts_pkg::START_W-1:0] to_start(input logic [OB-1:0] x);
        logic [SW-1:0] w;
        w = SW'(x);
        return w[dts_pkg::START_W-1:0];
    endfunction

    // Wrapped distance to saturated length field
    function automatic logic [dts_pkg::LEN_W-1:0] to_len(input logic [OB-1:0] x);
        logic [DW-1:0] w;
        w = DW'(x);
        if (w > DW'(16'hFFFF))
            return 16'hFFFF;
        return w[dts_pkg::LEN_W-1:0];
    endfunction

    always_comb
    begin
        logic [LW-1:0] lw;
        lw = LW'(line_reg);
        line_out = lw[dts_pkg::LINE_W-1:0];
    end

    // Character classes and spans
    assign c       = source_byte;
    assign c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
                     || c == dts_pkg::CH_UNDER;
    assign c_digit = (c >= "0" && c <= "9");
    assign d0      = off_reg - tstart_reg;
    assign dm1     = d0 - OB'(1);
    assign dp1     = d0 + OB'(1);
    assign dot_off = off_reg - OB'(1);

    // Keyword match on the open identifier
    always_comb
    begin
        logic hit;
        logic found;
        word_kind = dts_pkg::KIND_IDENT;
        found     = 1'b0;
        for (int k = 0; k < dts_pkg::KwCount; k++)
        begin
            hit = (d0 == OB'(dts_pkg::KW_LEN[k]))
                  && (wlen_reg >= WLW'(dts_pkg::KW_LEN[k]));
            for (int i = 0; i < dts_pkg::KwMax; i++)
            begin
                if (i < int'(dts_pkg::KW_LEN[k]) && word_reg[i] != dts_pkg::KW_TEXT[k][i])
                    hit = 1'b0;
            end
            if (hit && !found)
            begin
                word_kind = 5'(k + 1);
                found     = 1'b1;
            end
        end
    end

    // Byte taken in between tokens
    always_comb
    begin
        idle_valid     = 1'b0;
        idle_mode      = MODE_IDLE;
        idle_tok       = '0;
        idle_tok.start = to_start(off_reg);
        idle_tok.line  = line_out;
        idle_tok.len   = 16'd1;
        priority if (c == dts_pkg::CH_NUL)
        begin
            idle_valid    = 1'b1;
            idle_tok.kind = dts_pkg::KIND_EOF;
            idle_tok.len  = '0;
        end
        else if (c == dts_pkg::CH_LF || c == dts_pkg::CH_SPACE || c == dts_pkg::CH_CR
                 || c == dts_pkg::CH_TAB)
            idle_mode = MODE_IDLE;
        else if (c == dts_pkg::CH_HASH)
            idle_mode = MODE_COMMENT;
        else if (c_alpha)
            idle_mode = MODE_IDENT;
        else if (c_digit)
            idle_mode = MODE_INT;
        else if (c == dts_pkg::CH_DASH)
            idle_mode = MODE_DASH;
        else if (c == dts_pkg::CH_QUOTE)
            idle_mode = MODE_STRING;
        else
        begin
            idle_valid    = 1'b1;
            idle_tok.kind = dts_pkg::KIND_ERROR;
            idle_tok.err  = dts_pkg::ERR_UNEXPEC;
            for (int k = 0; k < dts_pkg::PunctCount; k++)
            begin
                if (c == dts_pkg::PUNCT[k])
                begin
                    idle_tok.kind = dts_pkg::KIND_PUNCT_BASE + 5'(k);
                    idle_tok.err  = dts_pkg::ERR_NONE;
                end
            end
        end
    end

    // Token closed by this byte in the current mode
    always_comb
    begin
        take_idle      = 1'b0;
        prim_valid     = 1'b0;
        dot_valid      = 1'b0;
        mode_next      = mode_reg;
        word_append    = 1'b0;
        prim_tok       = '0;
        prim_tok.start = to_start(tstart_reg);
        prim_tok.line  = line_out;
        prim_tok.len   = to_len(d0);
        dot_tok        = '0;
        dot_tok.kind   = dts_pkg::KIND_ERROR;
        dot_tok.err    = dts_pkg::ERR_UNEXPEC;
        dot_tok.start  = to_start(dot_off);
        dot_tok.len    = 16'd1;
        dot_tok.line   = line_out;
        unique case (mode_reg)
            MODE_IDLE:
                take_idle = 1'b1;
            MODE_COMMENT:
                take_idle = (c == dts_pkg::CH_NUL || c == dts_pkg::CH_LF);
            MODE_IDENT:
            begin
                if (c_alpha || c_digit)
                    word_append = (wlen_reg < WLW'(KC));
                else
                begin
                    prim_valid    = 1'b1;
                    prim_tok.kind = word_kind;
                    take_idle     = 1'b1;
                end
            end
            MODE_INT:
            begin
                if (c == dts_pkg::CH_DOT)
                    mode_next = MODE_DOT;
                else if (!c_digit)
                begin
                    prim_valid    = 1'b1;
                    prim_tok.kind = dts_pkg::KIND_NUMBER;
                    take_idle     = 1'b1;
                end
            end
            MODE_DOT:
            begin
                if (c_digit)
                    mode_next = MODE_FRAC;
                else
                begin
                    prim_valid    = 1'b1;
                    prim_tok.kind = dts_pkg::KIND_NUMBER;
                    prim_tok.len  = to_len(dm1);
                    dot_valid     = 1'b1;
                    take_idle     = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (!c_digit)
                begin
                    prim_valid    = 1'b1;
                    prim_tok.kind = dts_pkg::KIND_NUMBER;
                    take_idle     = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (c == dts_pkg::CH_QUOTE)
                begin
                    prim_valid    = 1'b1;
                    prim_tok.kind = dts_pkg::KIND_STRING;
                    prim_tok.len  = to_len(dp1);
                    mode_next     = MODE_IDLE;
                end
                else if (c == dts_pkg::CH_NUL || c == dts_pkg::CH_LF)
                begin
                    prim_valid    = 1'b1;
                    prim_tok.kind = dts_pkg::KIND_ERROR;
                    prim_tok.err  = dts_pkg::ERR_UNTERM;
                    take_idle     = 1'b1;
                end
            end
            MODE_DASH:
            begin
                prim_valid = 1'b1;
                if (c == dts_pkg::CH_GT)
                begin
                    prim_tok.kind = dts_pkg::KIND_ARROW;
                    prim_tok.len  = 16'd2;
                    mode_next     = MODE_IDLE;
                end
                else
                begin
                    prim_tok.kind = dts_pkg::KIND_ERROR;
                    prim_tok.err  = dts_pkg::ERR_ARROW;
                    prim_tok.len  = 16'd1;
                    take_idle     = 1'b1;
                end
            end
            default:
                take_idle = 1'b1;
        endcase
        if (take_idle)
            mode_next = idle_mode;
    end

    // Next state of the counters
    assign eof        = take_idle && (c == dts_pkg::CH_NUL);
    assign word_start = take_idle && c_alpha;

    always_comb
    begin
        off_next    = off_reg + OB'(1);
        tstart_next = take_idle ? off_reg : tstart_reg;
        line_next   = line_reg;
        wlen_next   = wlen_reg;
        if (take_idle && c == dts_pkg::CH_LF && line_reg != '1)
            line_next = line_reg + LB'(1);
        if (word_append)
            wlen_next = wlen_reg + WLW'(1);
        else if (word_start)
            wlen_next = WLW'(1);
        if (eof)
        begin
            off_next    = '0;
            tstart_next = '0;
            line_next   = LB'(1);
            wlen_next   = '0;
        end
    end

    // Pack the tokens of this byte in order
    always_comb
    begin
        new_cnt     = 2'(prim_valid) + 2'(dot_valid) + 2'(take_idle && idle_valid);
        new_slot[0] = prim_valid ? prim_tok : idle_tok;
        new_slot[1] = dot_valid ? dot_tok : idle_tok;
        new_slot[2] = idle_tok;
        for (int i = 0; i < 3; i++)
            new_slot[i].last = (new_cnt == 2'(i + 1));
    end

    // Handshake
    assign load         = (slot_cnt_reg != 2'd0) && (!out_valid_reg || !token_stall);
    assign can_take     = (slot_cnt_reg == 2'd0) || (slot_cnt_reg == 2'd1 && load);
    assign source_stall = !can_take;
    assign accept       = source_valid && can_take;

    // State, burst buffer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            off_reg       <= '0;
            tstart_reg    <= '0;
            line_reg      <= LB'(1);
            wlen_reg      <= '0;
            slot_cnt_reg  <= 2'd0;
            slot_reg      <= '{default: '0};
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= eof ? MODE_IDLE : mode_next;
                off_reg    <= off_next;
                tstart_reg <= tstart_next;
                line_reg   <= line_next;
                wlen_reg   <= wlen_next;
            end
            if (accept)
            begin
                slot_reg     <= new_slot;
                slot_cnt_reg <= new_cnt;
            end
            else if (load)
            begin
                slot_reg[0]  <= slot_reg[1];
                slot_reg[1]  <= slot_reg[2];
                slot_cnt_reg <= slot_cnt_reg - 2'd1;
            end
            if (!out_valid_reg || !token_stall)
            begin
                out_valid_reg <= load;
                out_reg       <= slot_reg[0];
            end
        end
    end

    // Identifier character store
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < KC; i++)
            begin
                if ((word_append && wlen_reg == WLW'(i)) || (word_start && i == 0))
                    word_reg[i] <= c;
            end
        end
    end

    // Output ports
    assign token_valid  = out_valid_reg;
    assign token_kind   = out_reg.kind;
    assign error_kind   = out_reg.err;
    assign start_offset = out_reg.start;
    assign token_length = out_reg.len;
    assign line_number  = out_reg.line;
    assign last_of_run  = out_reg.last;

endmodule

>>> test/dsl_token_scanner_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsl_token_scanner_unit_tb
// Self-checking bench for the streaming token scanner.
// ----------------------------------------------------------------------------
// Source bytes go in through the valid/stall channel. A scanner model in the
// bench predicts the token words that each accepted byte closes. A checker
// compares every output word with the oldest prediction. Directed source text
// covers each error path, each non-keyword kind and enum. Random well-formed
// text follows, mixed with noise bytes. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module dsl_token_scanner_unit_tb;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 10;

    // Scanner modes of the model
    typedef enum logic [2:0] {
        SC_IDLE, SC_COMMENT, SC_IDENT, SC_INT, SC_DOT, SC_FRAC, SC_STRING, SC_DASH
    } scan_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        source_valid = 1'b0;
    logic        source_stall;
    logic [7:0]  source_byte = 8'h00;
    logic        token_valid;
    logic        token_stall = 1'b0;
    logic [4:0]  token_kind;
    logic [1:0]  error_kind;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    // Scanner model state
    scan_mode_t       scan_state;
    logic [23:0]      cur_offset;
    logic [23:0]      open_start;
    logic [15:0]      cur_line;
    logic [7:0]       word_buf [dts_pkg::KwMax];
    int               word_fill;
    logic             eof_seen;
    dts_pkg::token_t  new_tokens [$];
    dts_pkg::token_t  pending_tokens [$];

    // Bench bookkeeping
    int               mismatches = 0;
    int               bytes_sent = 0;
    int               quiet_cycles = 0;
    logic             steady = 1'b0;
    dts_pkg::token_t  seen_tok;
    dts_pkg::token_t  want_tok;

    dsl_token_scanner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_valid (source_valid),
        .source_stall (source_stall),
        .source_byte  (source_byte),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .error_kind   (error_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_number  (line_number),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == dts_pkg::CH_UNDER;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Wrapped offset difference, clipped to the length field
    function automatic logic [15:0] clip_span(input logic [23:0] from_off,
                                              input logic [23:0] to_off);
        logic [23:0] d;
        d = to_off - from_off;
        return (d > 24'hFFFF) ? 16'hFFFF : d[15:0];
    endfunction

    function automatic void note_token(input logic [4:0] kind, input logic [1:0] err,
                                       input logic [23:0] start, input logic [15:0] len);
        dts_pkg::token_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = start;
        t.len   = len;
        t.line  = cur_line;
        t.last  = 1'b0;
        new_tokens.push_back(t);
    endfunction

    // Keyword only if the whole word is held and matches one spelling
    function automatic logic [4:0] word_kind(input logic [23:0] len);
        logic same;
        for (int k = 0; k < dts_pkg::KwCount; k++)
        begin
            if (len == 24'(dts_pkg::KW_LEN[k]) && word_fill >= int'(dts_pkg::KW_LEN[k]))
            begin
                same = 1'b1;
                for (int j = 0; j < int'(dts_pkg::KW_LEN[k]); j++)
                    if (word_buf[j] != dts_pkg::KW_TEXT[k][j])
                        same = 1'b0;
                if (same)
                    return 5'(k + 1);
            end
        end
        return dts_pkg::KIND_IDENT;
    endfunction

    // Byte taken in between tokens
    function automatic void take_between(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        scan_state = SC_IDLE;
        open_start = cur_offset;
        if (c == dts_pkg::CH_NUL)
        begin
            note_token(dts_pkg::KIND_EOF, dts_pkg::ERR_NONE, cur_offset, 16'd0);
            eof_seen = 1'b1;
        end
        else if (c == dts_pkg::CH_LF)
        begin
            if (cur_line != 16'hFFFF)
                cur_line = cur_line + 16'd1;
        end
        else if (c == dts_pkg::CH_HASH)
            scan_state = SC_COMMENT;
        else if (is_letter(c))
        begin
            word_buf[0] = c;
            word_fill = 1;
            scan_state = SC_IDENT;
        end
        else if (is_numeral(c))
            scan_state = SC_INT;
        else if (c == dts_pkg::CH_DASH)
            scan_state = SC_DASH;
        else if (c == dts_pkg::CH_QUOTE)
            scan_state = SC_STRING;
        else if (c != dts_pkg::CH_SPACE && c != dts_pkg::CH_CR && c != dts_pkg::CH_TAB)
        begin
            for (int k = 0; k < dts_pkg::PunctCount; k++)
            begin
                if (c == dts_pkg::PUNCT[k])
                begin
                    note_token(dts_pkg::KIND_PUNCT_BASE + 5'(k), dts_pkg::ERR_NONE,
                               cur_offset, 16'd1);
                    hit = 1'b1;
                end
            end
            if (!hit)
                note_token(dts_pkg::KIND_ERROR, dts_pkg::ERR_UNEXPEC, cur_offset, 16'd1);
        end
    endfunction

    // Advance the model by one accepted byte and queue the words it closes
    function automatic void predict_tokens(input logic [7:0] c);
        logic [23:0] dot_at;
        new_tokens.delete();
        eof_seen = 1'b0;
        case (scan_state)
            SC_COMMENT:
                if (c == dts_pkg::CH_NUL || c == dts_pkg::CH_LF)
                    take_between(c);
            SC_IDENT:
                if (is_letter(c) || is_numeral(c))
                begin
                    if (word_fill < dts_pkg::KwMax)
                    begin
                        word_buf[word_fill] = c;
                        word_fill++;
                    end
                end
                else
                begin
                    note_token(word_kind(cur_offset - open_start), dts_pkg::ERR_NONE,
                               open_start, clip_span(open_start, cur_offset));
                    take_between(c);
                end
            SC_INT:
                if (c == dts_pkg::CH_DOT)
                    scan_state = SC_DOT;
                else if (!is_numeral(c))
                begin
                    note_token(dts_pkg::KIND_NUMBER, dts_pkg::ERR_NONE, open_start,
                               clip_span(open_start, cur_offset));
                    take_between(c);
                end
            SC_DOT:
                if (is_numeral(c))
                    scan_state = SC_FRAC;
                else
                begin
                    // bare '.': number stops before it, the dot is an error
                    dot_at = cur_offset - 24'd1;
                    note_token(dts_pkg::KIND_NUMBER, dts_pkg::ERR_NONE, open_start,
                               clip_span(open_start, dot_at));
                    note_token(dts_pkg::KIND_ERROR, dts_pkg::ERR_UNEXPEC, dot_at, 16'd1);
                    take_between(c);
                end
            SC_FRAC:
                if (!is_numeral(c))
                begin
                    note_token(dts_pkg::KIND_NUMBER, dts_pkg::ERR_NONE, open_start,
                               clip_span(open_start, cur_offset));
                    take_between(c);
                end
            SC_STRING:
                if (c == dts_pkg::CH_QUOTE)
                begin
                    note_token(dts_pkg::KIND_STRING, dts_pkg::ERR_NONE, open_start,
                               clip_span(open_start, cur_offset + 24'd1));
                    scan_state = SC_IDLE;
                end
                else if (c == dts_pkg::CH_NUL || c == dts_pkg::CH_LF)
                begin
                    note_token(dts_pkg::KIND_ERROR, dts_pkg::ERR_UNTERM, open_start,
                               clip_span(open_start, cur_offset));
                    take_between(c);
                end
            SC_DASH:
                if (c == dts_pkg::CH_GT)
                begin
                    note_token(dts_pkg::KIND_ARROW, dts_pkg::ERR_NONE, open_start, 16'd2);
                    scan_state = SC_IDLE;
                end
                else
                begin
                    note_token(dts_pkg::KIND_ERROR, dts_pkg::ERR_ARROW, open_start, 16'd1);
                    take_between(c);
                end
            default:
                take_between(c);
        endcase

        // end of source restarts the scan
        if (eof_seen)
        begin
            scan_state = SC_IDLE;
            cur_offset = '0;
            open_start = '0;
            cur_line   = 16'd1;
            word_fill  = 0;
        end
        else
            cur_offset = cur_offset + 24'd1;

        if (new_tokens.size() != 0)
            new_tokens[new_tokens.size() - 1].last = 1'b1;
        foreach (new_tokens[i])
            pending_tokens.push_back(new_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < 6)
        begin
            source_valid <= 1'b0;
            @(posedge clk);
        end
        source_valid <= 1'b1;
        source_byte  <= b;
        @(posedge clk);
        while (source_stall)
            @(posedge clk);
        predict_tokens(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Hold the source until every predicted word has come out
    task automatic wait_drained();
        source_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return dts_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_alnum();
        if ($urandom_range(3) == 0)
            return 8'("0" + $urandom_range(9));
        return pick_letter();
    endfunction

    // One random piece of source: mostly well-formed tokens, some noise
    task automatic send_random_piece();
        string      keywords [dts_pkg::KwCount];
        logic [7:0] c;
        int         n;
        int         k;
        keywords = '{"define", "enum", "generate", "include", "strings"};
        case ($urandom_range(12))
            0, 1:
                if ($urandom_range(1) == 0)
                begin
                    k = $urandom_range(dts_pkg::KwCount - 1);
                    n = $urandom_range(3);
                    // occasionally cut short or run on past the keyword
                    if (n == 0)
                        send_text(keywords[k].substr(0, keywords[k].len() - 2));
                    else
                        send_text(keywords[k]);
                    if (n == 1)
                        send_byte(pick_alnum());
                end
                else
                begin
                    send_byte(pick_letter());
                    repeat ($urandom_range(11)) send_byte(pick_alnum());
                end
            2, 3:
            begin
                repeat ($urandom_range(4, 1)) send_byte(8'("0" + $urandom_range(9)));
                if ($urandom_range(1) == 0)
                begin
                    send_byte(dts_pkg::CH_DOT);
                    repeat ($urandom_range(3)) send_byte(8'("0" + $urandom_range(9)));
                end
            end
            4:
            begin
                send_byte(dts_pkg::CH_QUOTE);
                repeat ($urandom_range(6))
                begin
                    do
                        c = 8'($urandom_range(126, 32));
                    while (c == dts_pkg::CH_QUOTE);
                    send_byte(c);
                end
                send_byte(($urandom_range(3) == 0) ? dts_pkg::CH_LF : dts_pkg::CH_QUOTE);
            end
            5:
                send_byte(dts_pkg::PUNCT[$urandom_range(dts_pkg::PunctCount - 1)]);
            6:
            begin
                send_byte(dts_pkg::CH_DASH);
                if ($urandom_range(2) != 0)
                    send_byte(dts_pkg::CH_GT);
            end
            7:
            begin
                send_byte(dts_pkg::CH_HASH);
                repeat ($urandom_range(5))
                begin
                    do
                        c = 8'($urandom_range(255, 1));
                    while (c == dts_pkg::CH_LF);
                    send_byte(c);
                end
                send_byte(($urandom_range(4) == 0) ? dts_pkg::CH_NUL : dts_pkg::CH_LF);
            end
            8, 9:
                repeat ($urandom_range(3, 1))
                begin
                    n = $urandom_range(3);
                    send_byte(n == 0 ? dts_pkg::CH_SPACE : n == 1 ? dts_pkg::CH_TAB :
                              n == 2 ? dts_pkg::CH_CR : dts_pkg::CH_LF);
                end
            10:
                send_byte(8'($urandom_range(255, 1)));
            11:
                send_byte(($urandom_range(3) == 0) ? dts_pkg::CH_NUL : dts_pkg::CH_SPACE);
            default:
                ; // tokens packed back to back
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // identifier closed by a punctuator, then every punctuator
    task automatic test_punctuators();
        send_text("a1:,*(){}[] ");
    endtask

    // arrow, then a dash followed by something else
    task automatic test_arrow_and_dash();
        send_text("->-x ");
    endtask

    // fraction, bare dot with a third token, number closed by ')'
    task automatic test_numbers();
        send_text("7.5 3.;0)");
        wait_drained();
    endtask

    task automatic test_keywords();
        send_text("enum,");
    endtask

    // closed string, newline inside a string, end of source inside a string
    task automatic test_strings();
        send_text("\"q\"\"u\n\"");
        send_byte(dts_pkg::CH_NUL);
    endtask

    // comment to newline, high bytes, identifier closed by end of source
    task automatic test_comments_and_odd_bytes();
        send_text("#c\n");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("Z_");
        send_byte(dts_pkg::CH_NUL);
    endtask

    task automatic test_random_source();
        int first;
        logic paused;
        first  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - first < 95)
        begin
            steady = (bytes_sent - first >= 35) && (bytes_sent - first < 70);
            if (!paused && bytes_sent - first >= 55)
            begin
                wait_drained();
                paused = 1'b1;
            end
            send_random_piece();
        end
        steady = 1'b0;
        send_byte(dts_pkg::CH_NUL);
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token_valid && !token_stall)
            begin
                seen_tok = '{kind: token_kind, err: error_kind, start: start_offset,
                             len: token_length, line: line_number, last: last_of_run};
                if (pending_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected word kind=%0d err=%0d start=%0d len=%0d",
                                 $realtime, seen_tok.kind, seen_tok.err, seen_tok.start,
                                 seen_tok.len);
                end
                else
                begin
                    want_tok = pending_tokens.pop_front();
                    if (seen_tok.kind !== want_tok.kind || seen_tok.err !== want_tok.err ||
                        seen_tok.start !== want_tok.start || seen_tok.len !== want_tok.len ||
                        seen_tok.line !== want_tok.line || seen_tok.last !== want_tok.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: expected kind=%0d err=%0d start=%0d len=%0d",
                                     $realtime, want_tok.kind, want_tok.err,
                                     want_tok.start, want_tok.len,
                                     " line=%0d last=%0b,", want_tok.line, want_tok.last,
                                     " got kind=%0d err=%0d start=%0d len=%0d",
                                     seen_tok.kind, seen_tok.err, seen_tok.start,
                                     seen_tok.len,
                                     " line=%0d last=%0b", seen_tok.line, seen_tok.last);
                    end
                end
            end
            token_stall <= !steady && ($urandom_range(99) < 6);
        end
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((source_valid && !source_stall) || (token_valid && !token_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("dsl_token_scanner_unit: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        scan_state = SC_IDLE;
        cur_offset = '0;
        open_start = '0;
        cur_line   = 16'd1;
        word_fill  = 0;
        eof_seen   = 1'b0;
        foreach (word_buf[i])
            word_buf[i] = 8'h00;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_punctuators();
        test_arrow_and_dash();
        test_numbers();
        test_keywords();
        test_strings();
        test_comments_and_odd_bytes();
        test_random_source();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("dsl_token_scanner_unit: match");
        else
            $display("dsl_token_scanner_unit: mismatch");
        $finish;
    end

endmodule
